// ===== hdl/brf_pkg.sv =====
// brf_pkg: shared types and codes for the circular byte fifo
// used by brf_ctrl, brf_dp and byte_ring_fifo_top; no dependencies
package brf_pkg;

    localparam int CW = 13;
    localparam int DW = 8;

    // action codes
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_SHORT    = 2'd2;
    localparam logic [1:0] ST_TOO_LONG = 2'd3;

    typedef struct packed {
        logic [1:0]    action;
        logic          first_of_transfer;
        logic [CW-1:0] transfer_len;
        logic [DW-1:0] write_data;
    } t_item;

    typedef struct packed {
        logic [1:0]    status;
        logic          data_valid;
        logic [DW-1:0] read_data;
        logic          last;
        logic [CW-1:0] bytes_stored;
        logic [CW-1:0] space_free;
    } t_result;

    typedef struct packed {
        logic exec_single;
        logic rd_issue;
        logic rd_last;
    } t_dp_cmd;

    typedef struct packed {
        logic len_fits;
    } t_dp_stat;

endpackage

// ===== hdl/brf_ctrl.sv =====
// brf_ctrl: item acceptance and read-burst sequencer
// depends on brf_pkg; drives brf_dp through t_dp_cmd
module brf_ctrl #(
    parameter int MAX_READ = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  brf_pkg::t_item     i_item,
    input  brf_pkg::t_dp_stat  i_stat,
    output brf_pkg::t_dp_cmd   o_cmd
);
    import brf_pkg::*;

    localparam int RCW = $clog2(MAX_READ + 1);
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_READ);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_READ = 2'b10
    } t_state;

    t_state          r_state, n_state;
    logic [RCW-1:0]  r_rd_left, n_rd_left;
    logic            accept;
    logic            go_read;

    assign busy   = (r_state == S_READ);
    assign accept = start && !busy;
    assign go_read = (i_item.action == ACT_READ) && (i_item.transfer_len != '0)
                     && (i_item.transfer_len <= MAX_LEN) && i_stat.len_fits;

    always_comb begin
        n_state   = r_state;
        n_rd_left = r_rd_left;
        o_cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (go_read) begin
                        n_state   = S_READ;
                        n_rd_left = i_item.transfer_len[RCW-1:0];
                    end else begin
                        o_cmd.exec_single = 1'b1;
                    end
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                o_cmd.rd_last  = (r_rd_left == RCW'(1));
                n_rd_left      = r_rd_left - RCW'(1);
                if (r_rd_left == RCW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_left <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_left <= n_rd_left;
        end
    end

`ifndef SYNTHESIS
    a_burst_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ && r_rd_left == RCW'(1)) |=> (r_state == S_IDLE))
        else $error("read burst did not end after its last byte");
    a_burst_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.rd_issue |-> (r_rd_left != '0))
        else $error("read issued with no bytes left");
    a_no_single_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !o_cmd.exec_single)
        else $error("single-result item executed during a read burst");
`endif

endmodule

// ===== hdl/brf_dp.sv =====
// brf_dp: ring state, byte memory, admission logic and result register
// depends on brf_pkg; commanded by brf_ctrl
module brf_dp #(
    parameter int DEPTH    = 4096,
    parameter int MAX_READ = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  brf_pkg::t_item             i_item,
    input  logic                       i_cfg_we,
    input  logic [brf_pkg::CW-1:0]     i_cfg_wdata,
    input  brf_pkg::t_dp_cmd           i_cmd,
    output brf_pkg::t_dp_stat          o_stat,
    output logic                       o_strobe,
    output brf_pkg::t_result           o_result
);
    import brf_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int PW = (AW > CW) ? AW : CW;
    localparam logic [CW-1:0] CAP_RESET = CW'((DEPTH < 4096) ? DEPTH : 4096);
    localparam bit            DEPTH_LIMITS = (DEPTH < (1 << CW));
    localparam logic [CW-1:0] DEPTH_W =
        CW'((DEPTH < (1 << CW)) ? DEPTH : ((1 << CW) - 1));
    localparam logic [CW-1:0] MAX_LEN = CW'(MAX_READ);

    logic [DW-1:0] r_mem [DEPTH];

    logic [CW-1:0] r_cap, n_cap;
    logic [PW-1:0] r_rd_pos, n_rd_pos;
    logic [CW-1:0] r_stored, n_stored;
    logic [CW-1:0] r_wr_left, n_wr_left;
    logic          r_drop, n_drop;
    logic          r_out_valid, n_out_valid;
    t_result       r_out, n_out;
    logic [DW-1:0] r_rd_data;

    logic          mem_we;
    logic [AW-1:0] wr_addr;
    logic [PW:0]   wr_sum;
    logic [PW:0]   rd_inc;
    logic [CW:0]   need_sum;
    logic [CW-1:0] tr_len;
    logic          new_tr;
    logic [CW-1:0] wr_left_a;
    logic          drop_a;
    logic [CW-1:0] cfg_cap;

    assign o_stat.len_fits = (i_item.transfer_len <= r_stored);

    // ring slot after the newest byte
    assign wr_sum  = (PW+1)'(r_rd_pos) + (PW+1)'(r_stored);
    assign rd_inc  = (PW+1)'(r_rd_pos) + (PW+1)'(1);

    always_comb begin
        if (wr_sum >= (PW+1)'(r_cap)) begin
            wr_addr = AW'(wr_sum - (PW+1)'(r_cap));
        end else begin
            wr_addr = AW'(wr_sum);
        end
    end

    // transfer admission
    always_comb begin
        new_tr = i_item.first_of_transfer || (r_wr_left == '0);
        if (i_item.first_of_transfer && i_item.transfer_len != '0) begin
            tr_len = i_item.transfer_len;
        end else begin
            tr_len = CW'(1);
        end
        need_sum  = {1'b0, r_stored} + {1'b0, tr_len};
        wr_left_a = new_tr ? tr_len : r_wr_left;
        drop_a    = new_tr ? (need_sum > {1'b0, r_cap}) : r_drop;
    end

    always_comb begin
        if (i_cfg_wdata == '0) begin
            cfg_cap = CW'(1);
        end else if (DEPTH_LIMITS && i_cfg_wdata > DEPTH_W) begin
            cfg_cap = DEPTH_W;
        end else begin
            cfg_cap = i_cfg_wdata;
        end
    end

    always_comb begin
        n_cap       = r_cap;
        n_rd_pos    = r_rd_pos;
        n_stored    = r_stored;
        n_wr_left   = r_wr_left;
        n_drop      = r_drop;
        n_out_valid = 1'b0;
        n_out       = r_out;
        mem_we      = 1'b0;

        if (i_cfg_we) begin
            n_cap     = cfg_cap;
            n_rd_pos  = '0;
            n_stored  = '0;
            n_wr_left = '0;
            n_drop    = 1'b0;
        end else if (i_cmd.exec_single) begin
            n_out_valid      = 1'b1;
            n_out.status     = ST_OK;
            n_out.data_valid = 1'b0;
            n_out.read_data  = '0;
            n_out.last       = 1'b1;
            case (i_item.action)
                ACT_WRITE: begin
                    n_wr_left = wr_left_a - CW'(1);
                    n_drop    = (n_wr_left == '0) ? 1'b0 : drop_a;
                    if (drop_a || r_stored >= r_cap) begin
                        n_out.status = ST_OVERFLOW;
                    end else begin
                        mem_we   = 1'b1;
                        n_stored = r_stored + CW'(1);
                    end
                end
                ACT_READ: begin
                    // only error or zero-length reads end up here
                    if (i_item.transfer_len > MAX_LEN) begin
                        n_out.status = ST_TOO_LONG;
                    end else if (i_item.transfer_len > r_stored) begin
                        n_out.status = ST_SHORT;
                    end
                end
                ACT_CLEAR: begin
                    n_rd_pos = '0;
                    n_stored = '0;
                end
                default: begin
                end
            endcase
            n_out.bytes_stored = n_stored;
            n_out.space_free   = r_cap - n_stored;
        end else if (i_cmd.rd_issue) begin
            n_out_valid        = 1'b1;
            n_rd_pos           = (rd_inc >= (PW+1)'(r_cap)) ? '0 : PW'(rd_inc);
            n_stored           = r_stored - CW'(1);
            n_out.status       = ST_OK;
            n_out.data_valid   = 1'b1;
            n_out.read_data    = '0;
            n_out.last         = i_cmd.rd_last;
            n_out.bytes_stored = n_stored;
            n_out.space_free   = r_cap - n_stored;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= i_item.write_data;
        end
        if (i_cmd.rd_issue) begin
            r_rd_data <= r_mem[r_rd_pos[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_rd_pos    <= '0;
            r_stored    <= '0;
            r_wr_left   <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cap       <= n_cap;
            r_rd_pos    <= n_rd_pos;
            r_stored    <= n_stored;
            r_wr_left   <= n_wr_left;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_strobe = r_out_valid;

    always_comb begin
        o_result           = r_out;
        o_result.read_data = r_out.data_valid ? r_rd_data : '0;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stored <= r_cap)
        else $error("fill level above capacity");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (PW+1)'(r_rd_pos) < (PW+1)'(r_cap))
        else $error("read position outside the ring");
    a_byte_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && r_out.data_valid) |-> $past(i_cmd.rd_issue))
        else $error("data item without a memory read");
`endif

endmodule

// ===== hdl/byte_ring_fifo_top.sv =====
// byte_ring_fifo_top: circular byte fifo, controller plus datapath
// depends on brf_pkg, brf_ctrl and brf_dp
//
// Items are taken when start is high and busy is low. Writes, clears, zero-length
// and rejected reads never raise busy and can be given back to back; their single
// result is on o_result with o_res_strobe in the cycle after the item is taken.
// A read of N bytes (1..MAX_READ, no more than stored) holds busy high while it runs,
// one byte per cycle out of the single read port of the byte memory; each byte is
// registered from the memory read, the final one flagged by last.
// Results are shown for one cycle only and cannot be held off by the receiver.
// The byte memory needs no clearing after reset; the block takes items right away.
module byte_ring_fifo_top #(
    parameter int DEPTH    = 4096,
    parameter int MAX_READ = 64
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  brf_pkg::t_item          i_item,
    input  logic                    i_cfg_we,
    input  logic [brf_pkg::CW-1:0]  i_cfg_wdata,
    output logic                    o_res_strobe,
    output brf_pkg::t_result        o_result
);
    import brf_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    brf_ctrl #(
        .MAX_READ (MAX_READ)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    brf_dp #(
        .DEPTH    (DEPTH),
        .MAX_READ (MAX_READ)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_strobe    (o_res_strobe),
        .o_result    (o_result)
    );

endmodule

// ===== verif/testbench.sv =====
// testbench for byte_ring_fifo_top: directed and random items checked by a scoreboard
// depends on brf_pkg and byte_ring_fifo_top; the scoreboard models the ring byte by byte
`timescale 1ns / 1ps

module testbench;
    import brf_pkg::*;

    localparam int RING_DEPTH  = 4096;
    localparam int READ_LIMIT  = 64;
    localparam int CYCLE_LIMIT = 500000;
    localparam int ITEMS_PER_PHASE = 33;
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    class ring_scoreboard;
        bit [7:0]    ring_bytes [RING_DEPTH];
        int unsigned head;
        int unsigned held;
        int unsigned xfer_left;
        int unsigned cap;
        bit          rejecting;
        t_result     due_results [$];
        int unsigned errors;
        int unsigned checked;

        function new();
            head = 0;
            held = 0;
            xfer_left = 0;
            rejecting = 0;
            cap = RING_DEPTH;
            errors = 0;
            checked = 0;
        endfunction

        function int pending();
            return due_results.size();
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= 60)
                $display("[%0t] mismatch on result %0d: %s", $time, checked, msg);
        endtask

        function void push_result(input logic [1:0] st, input bit dv, input bit [7:0] data,
                                  input bit fin);
            t_result r;
            r.status       = st;
            r.data_valid   = dv;
            r.read_data    = data;
            r.last         = fin;
            r.bytes_stored = held[CW-1:0];
            r.space_free   = CW'(cap - held);
            due_results.push_back(r);
        endfunction

        function void apply_capacity(input logic [CW-1:0] v);
            cap = v;
            if (cap == 0)
                cap = 1;
            if (cap > RING_DEPTH)
                cap = RING_DEPTH;
            head = 0;
            held = 0;
            xfer_left = 0;
            rejecting = 0;
        endfunction

        function void note_item(input t_item it);
            int unsigned n;
            int unsigned pos;
            logic [1:0]  st;
            case (it.action)
                ACT_WRITE: begin
                    if (it.first_of_transfer || xfer_left == 0) begin
                        n = it.first_of_transfer ? it.transfer_len : 1;
                        if (n == 0)
                            n = 1;
                        xfer_left = n;
                        rejecting = (held + n > cap);
                    end
                    xfer_left--;
                    if (rejecting || held >= cap) begin
                        st = ST_OVERFLOW;
                    end else begin
                        pos = head + held;
                        if (pos >= cap)
                            pos -= cap;
                        ring_bytes[pos] = it.write_data;
                        held++;
                        st = ST_OK;
                    end
                    if (xfer_left == 0)
                        rejecting = 0;
                    push_result(st, 0, 8'h00, 1);
                end
                ACT_READ: begin
                    // length limit is checked before the fill level
                    if (it.transfer_len > READ_LIMIT) begin
                        push_result(ST_TOO_LONG, 0, 8'h00, 1);
                    end else if (it.transfer_len > held) begin
                        push_result(ST_SHORT, 0, 8'h00, 1);
                    end else if (it.transfer_len == 0) begin
                        push_result(ST_OK, 0, 8'h00, 1);
                    end else begin
                        for (int i = 0; i < it.transfer_len; i++) begin
                            pos = head;
                            head = (head + 1 >= cap) ? 0 : head + 1;
                            held--;
                            push_result(ST_OK, 1, ring_bytes[pos], i + 1 == it.transfer_len);
                        end
                    end
                end
                ACT_CLEAR: begin
                    head = 0;
                    held = 0;
                    push_result(ST_OK, 0, 8'h00, 1);
                end
                default: begin
                    push_result(ST_OK, 0, 8'h00, 1);
                end
            endcase
        endfunction

        task check_result(input t_result got);
            t_result want;
            checked++;
            if (due_results.size() == 0) begin
                report("result with nothing expected");
            end else begin
                want = due_results.pop_front();
                if (got.status !== want.status)
                    report($sformatf("status %0d, want %0d", got.status, want.status));
                if (got.data_valid !== want.data_valid)
                    report($sformatf("data_valid %0b, want %0b", got.data_valid,
                                     want.data_valid));
                if (got.read_data !== want.read_data)
                    report($sformatf("read_data %02h, want %02h", got.read_data,
                                     want.read_data));
                if (got.last !== want.last)
                    report($sformatf("last %0b, want %0b", got.last, want.last));
                if (got.bytes_stored !== want.bytes_stored)
                    report($sformatf("bytes_stored %0d, want %0d", got.bytes_stored,
                                     want.bytes_stored));
                if (got.space_free !== want.space_free)
                    report($sformatf("space_free %0d, want %0d", got.space_free,
                                     want.space_free));
            end
        endtask
    endclass

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    t_item            i_item = '0;
    logic             i_cfg_we = 1'b0;
    logic [CW-1:0]    i_cfg_wdata = '0;
    logic             o_res_strobe;
    t_result          o_result;

    ring_scoreboard   sb = new();
    int unsigned      idle_pct = 0;
    int unsigned      items_sent = 0;
    int unsigned      cycles = 0;

    byte_ring_fifo_top #(
        .DEPTH    (RING_DEPTH),
        .MAX_READ (READ_LIMIT)
    ) u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_item       (i_item),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_res_strobe (o_res_strobe),
        .o_result     (o_result)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // values read here are the ones from before the edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_res_strobe)
                sb.check_result(o_result);
            if (start && !busy)
                sb.note_item(i_item);
        end
    end

    function automatic t_item mk_item(input logic [1:0] act, input bit first,
                                      input int unsigned len, input int unsigned data);
        t_item it;
        it.action            = act;
        it.first_of_transfer = first;
        it.transfer_len      = CW'(len);
        it.write_data        = DW'(data);
        return it;
    endfunction

    task automatic send_item(input t_item it);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start  <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (it.action != ACT_UNUSED)
            items_sent++;
    endtask

    task automatic drain();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0 || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CW-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        sb.apply_capacity(v);
        i_cfg_we    <= 1'b0;
    endtask

    // one write transfer; long or rejected ones are mostly cut short
    task automatic send_transfer();
        int unsigned len;
        int unsigned count;
        int unsigned roll;
        int unsigned lim;
        roll = $urandom_range(99);
        lim  = (sb.cap < 16) ? sb.cap : 16;
        if (roll < 65)
            len = $urandom_range(lim, 1);
        else if (roll < 80)
            len = $urandom_range(64, 17);
        else if (roll < 93)
            len = sb.cap - sb.held + $urandom_range(8, 1);
        else
            len = $urandom_range(8191, 0);
        count = (len > 64) ? $urandom_range(24, 2) : len;
        if (count == 0)
            count = 1;
        if (count > 1 && $urandom_range(9) == 0)
            count = $urandom_range(count - 1, 1);
        send_item(mk_item(ACT_WRITE, 1, len, $urandom_range(255)));
        for (int i = 1; i < count; i++)
            send_item(mk_item(ACT_WRITE, 0, $urandom_range(8191), $urandom_range(255)));
    endtask

    task automatic send_read();
        int unsigned len;
        int unsigned roll;
        int unsigned top;
        roll = $urandom_range(99);
        top  = (sb.held < READ_LIMIT) ? sb.held : READ_LIMIT;
        if (roll < 60 && top > 0)
            len = $urandom_range(top, 1);
        else if (roll < 68 && sb.held >= READ_LIMIT)
            len = READ_LIMIT;
        else if (roll < 80)
            len = $urandom_range(READ_LIMIT, 0);
        else if (roll < 88)
            len = 0;
        else
            len = $urandom_range(8191, READ_LIMIT + 1);
        send_item(mk_item(ACT_READ, $urandom_range(1), len, $urandom_range(255)));
    endtask

    task automatic run_phase(input int unsigned n);
        int unsigned stop_at;
        int unsigned roll;
        stop_at = items_sent + n;
        while (items_sent < stop_at) begin
            roll = $urandom_range(99);
            if (roll < 50)
                send_transfer();
            else if (roll < 85)
                send_read();
            else if (roll < 91)
                send_item(mk_item(ACT_WRITE, 0, $urandom_range(8191), $urandom_range(255)));
            else if (roll < 96)
                send_item(mk_item(ACT_CLEAR, $urandom_range(1), $urandom_range(8191),
                                  $urandom_range(255)));
            else
                send_item(mk_item(ACT_UNUSED, $urandom_range(1), $urandom_range(8191),
                                  $urandom_range(255)));
        end
    endtask

    task automatic run_directed();
        send_item(mk_item(ACT_READ, 0, 0, 8'h00));            // empty read of nothing
        send_item(mk_item(ACT_READ, 0, 1, 8'h00));            // not enough stored
        send_item(mk_item(ACT_READ, 1, READ_LIMIT + 1, 8'hff)); // too long beats too few
        send_item(mk_item(ACT_READ, 1, 8191, 8'hff));
        send_item(mk_item(ACT_UNUSED, 1, 8191, 8'hff));
        send_item(mk_item(ACT_WRITE, 1, 0, 8'hff));           // zero length acts as one byte
        send_item(mk_item(ACT_WRITE, 0, 8191, 8'h00));        // stray byte stands alone
        send_item(mk_item(ACT_WRITE, 1, 3, 8'ha5));
        send_item(mk_item(ACT_WRITE, 0, 0, 8'h5a));
        send_item(mk_item(ACT_WRITE, 1, 2, 8'h3c));           // new transfer abandons the old
        send_item(mk_item(ACT_WRITE, 0, 0, 8'hc3));
        send_item(mk_item(ACT_WRITE, 1, 3, 8'h11));
        send_item(mk_item(ACT_CLEAR, 0, 0, 8'h00));           // rest of transfer still lands
        send_item(mk_item(ACT_WRITE, 0, 0, 8'h22));
        send_item(mk_item(ACT_WRITE, 0, 0, 8'h33));
        send_item(mk_item(ACT_READ, 0, 2, 8'h00));
        send_item(mk_item(ACT_WRITE, 0, 0, 8'h77));
        send_item(mk_item(ACT_WRITE, 1, 8191, 8'h00));        // rejected, byte dropped
        send_item(mk_item(ACT_WRITE, 0, 0, 8'h88));           // dropped with its transfer
        send_item(mk_item(ACT_WRITE, 1, RING_DEPTH, 8'h55));  // one byte too many
        send_item(mk_item(ACT_WRITE, 1, RING_DEPTH - 1, 8'h99));
        send_item(mk_item(ACT_READ, 0, 2, 8'h00));
        send_item(mk_item(ACT_READ, 1, READ_LIMIT, 8'h00));
        send_item(mk_item(ACT_CLEAR, 1, 8191, 8'hff));
    endtask

    initial begin
        logic [CW-1:0] caps [8];
        caps = '{13'd0, 13'd37, 13'd8191, 13'd1, 13'd300, 13'd12, 13'd4096, 13'd64};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_phase(ITEMS_PER_PHASE);
        foreach (caps[p]) begin
            write_capacity(caps[p]);
            idle_pct = ((p + 1) % 3 == 0) ? 0 : (((p + 1) % 3 == 1) ? 56 : 10);
            run_phase(ITEMS_PER_PHASE);
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (sb.errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
